@@ src/cosc_pkg.sv @@
// Shared types and constants for the column occlusion span clipper.
// Used by cosc_front, cosc_back and the top level; no dependencies.
`default_nettype none
package cosc_pkg;

    localparam int COLS_DEF = 120;
    localparam int COL_W    = 7;
    localparam int END_W    = 8;
    localparam int Q_DEPTH  = 2;
    localparam int Q_AW     = 1;
    localparam int Q_CW     = 2;

    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_CLIP  = 1'b1;

    typedef struct packed {
        logic             is_clip;
        logic [COL_W-1:0] span_first;
        logic [END_W-1:0] span_end;
        logic             mark;
    } t_cmd;

endpackage
`default_nettype wire

@@ src/column_occlusion_span_clipper_top.sv @@
// Top level of the column occlusion span clipper: front queue and scan engine.
// Depends on cosc_pkg, cosc_front and cosc_back.
//
//   channel  dir  tdata                                   tuser    tlast
//   s_       in   span_first[6:0] span_end[14:7] mark[15] opcode   -
//   m_       out  run_start[6:0] run_stop[13:7]           visible  last
//
// A clear resets every column bit in the engine. A clip alternates between
// finding the start and the stop of each visible run with find-first scans
// over the column bits. A two-entry queue decouples input from the engine;
// the result register stalls the engine while it holds a result and
// m_tready is low. Synchronous active-low reset clears every column bit.
`default_nettype none
module column_occlusion_span_clipper_top #(
    parameter int SCREEN_COLUMNS = cosc_pkg::COLS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // span_first, span_end, marks_solid
    input  wire logic        s_tuser,   // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // run_start, run_stop, zero pad
    output logic             m_tuser,   // visible
    output logic             m_tlast    // last
);
    import cosc_pkg::*;

    t_cmd             cmd;
    logic             cmd_valid;
    logic             cmd_ready;
    logic [COL_W-1:0] run_start;
    logic [COL_W-1:0] run_stop;

    cosc_front #(
        .SCREEN_COLUMNS(SCREEN_COLUMNS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_tvalid),
        .o_req_ready  (s_tready),
        .i_opcode     (s_tuser),
        .i_span_first (s_tdata[6:0]),
        .i_span_end   (s_tdata[14:7]),
        .i_marks_solid(s_tdata[15]),
        .o_cmd_valid  (cmd_valid),
        .i_cmd_ready  (cmd_ready),
        .o_cmd        (cmd)
    );

    cosc_back #(
        .SCREEN_COLUMNS(SCREEN_COLUMNS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_res_valid (m_tvalid),
        .i_res_ready (m_tready),
        .o_run_start (run_start),
        .o_run_stop  (run_stop),
        .o_visible   (m_tuser),
        .o_last      (m_tlast)
    );

    assign m_tdata = {2'b00, run_stop, run_start};

endmodule
`default_nettype wire

@@ src/cosc_front.sv @@
// Front end: accepts requests, saturates the span end and queues commands.
// Depends on cosc_pkg.
`default_nettype none
module cosc_front #(
    parameter int SCREEN_COLUMNS = cosc_pkg::COLS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_req_valid,
    output logic                           o_req_ready,
    input  wire logic                      i_opcode,
    input  wire logic [cosc_pkg::COL_W-1:0] i_span_first,
    input  wire logic [cosc_pkg::END_W-1:0] i_span_end,
    input  wire logic                      i_marks_solid,
    output logic                           o_cmd_valid,
    input  wire logic                      i_cmd_ready,
    output cosc_pkg::t_cmd                 o_cmd
);
    import cosc_pkg::*;

    localparam logic [END_W-1:0] LP_COLS = END_W'(SCREEN_COLUMNS);

    t_cmd            r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_CW-1:0] r_cnt;
    t_cmd            n_cmd;
    logic            push;
    logic            pop;

    always_comb begin
        n_cmd.is_clip    = (i_opcode == OP_CLIP);
        n_cmd.span_first = i_span_first;
        n_cmd.span_end   = (i_span_end > LP_COLS) ? LP_COLS : i_span_end;
        n_cmd.mark       = i_marks_solid;
    end

    assign o_req_ready = (r_cnt != Q_CW'(Q_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd];
    assign push        = i_req_valid && o_req_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ src/cosc_back.sv @@
// Back end: holds the column solid bits, scans spans run by run and
// drives the registered result. Depends on cosc_pkg.
`default_nettype none
module cosc_back #(
    parameter int SCREEN_COLUMNS = cosc_pkg::COLS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cmd_valid,
    output logic                            o_cmd_ready,
    input  wire cosc_pkg::t_cmd             i_cmd,
    output logic                            o_res_valid,
    input  wire logic                       i_res_ready,
    output logic [cosc_pkg::COL_W-1:0]      o_run_start,
    output logic [cosc_pkg::COL_W-1:0]      o_run_stop,
    output logic                            o_visible,
    output logic                            o_last
);
    import cosc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND_LO,
        ST_FIND_HI
    } t_state;

    t_state                    r_state;
    logic [SCREEN_COLUMNS-1:0] r_solid;
    logic [END_W-1:0]          r_cur;
    logic [END_W-1:0]          r_end;
    logic                      r_mark;
    logic [COL_W-1:0]          r_lo;
    logic                      r_pend;
    logic [COL_W-1:0]          r_pend_lo;
    logic [COL_W-1:0]          r_pend_hi;
    logic                      r_out_valid;
    logic [COL_W-1:0]          r_out_start;
    logic [COL_W-1:0]          r_out_stop;
    logic                      r_out_vis;
    logic                      r_out_last;

    logic                      slot_free;
    logic                      emit;
    logic                      found_lo;
    logic [COL_W-1:0]          lo_idx;
    logic                      found_sol;
    logic [COL_W-1:0]          sol_idx;
    logic [COL_W-1:0]          hi_idx;
    logic [SCREEN_COLUMNS-1:0] run_mask;

    assign slot_free   = !r_out_valid || i_res_ready;
    assign emit        = slot_free && (((r_state == ST_FIND_LO) && !found_lo)
                                       || ((r_state == ST_FIND_HI) && r_pend));
    assign o_cmd_ready = (r_state == ST_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_run_start = r_out_start;
    assign o_run_stop  = r_out_stop;
    assign o_visible   = r_out_vis;
    assign o_last      = r_out_last;

    // lowest open column at or after the cursor
    always_comb begin
        found_lo = 1'b0;
        lo_idx   = '0;
        for (int i = SCREEN_COLUMNS - 1; i >= 0; i--) begin
            if (!r_solid[i] && (END_W'(i) >= r_cur) && (END_W'(i) < r_end)) begin
                found_lo = 1'b1;
                lo_idx   = COL_W'(i);
            end
        end
    end

    // lowest solid column after the run start closes the run
    always_comb begin
        found_sol = 1'b0;
        sol_idx   = '0;
        for (int i = SCREEN_COLUMNS - 1; i >= 0; i--) begin
            if (r_solid[i] && (COL_W'(i) > r_lo) && (END_W'(i) < r_end)) begin
                found_sol = 1'b1;
                sol_idx   = COL_W'(i);
            end
        end
        hi_idx = found_sol ? (sol_idx - 1'b1) : COL_W'(r_end - 1'b1);
    end

    always_comb begin
        for (int i = 0; i < SCREEN_COLUMNS; i++) begin
            run_mask[i] = (COL_W'(i) >= r_lo) && (COL_W'(i) <= hi_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_solid     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        if (!i_cmd.is_clip) begin
                            r_solid <= '0;
                        end else begin
                            r_cur   <= END_W'(i_cmd.span_first);
                            r_end   <= i_cmd.span_end;
                            r_mark  <= i_cmd.mark;
                            r_pend  <= 1'b0;
                            r_state <= ST_FIND_LO;
                        end
                    end
                end
                ST_FIND_LO: begin
                    if (found_lo) begin
                        r_lo    <= lo_idx;
                        r_state <= ST_FIND_HI;
                    end else if (slot_free) begin
                        r_out_start <= r_pend ? r_pend_lo : '0;
                        r_out_stop  <= r_pend ? r_pend_hi : '0;
                        r_out_vis   <= r_pend;
                        r_out_last  <= 1'b1;
                        r_pend      <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_FIND_HI: begin
                    if (!r_pend || slot_free) begin
                        if (r_pend) begin
                            r_out_start <= r_pend_lo;
                            r_out_stop  <= r_pend_hi;
                            r_out_vis   <= 1'b1;
                            r_out_last  <= 1'b0;
                        end
                        r_pend    <= 1'b1;
                        r_pend_lo <= r_lo;
                        r_pend_hi <= hi_idx;
                        r_cur     <= END_W'(hi_idx) + 1'b1;
                        if (r_mark) begin
                            r_solid <= r_solid | run_mask;
                        end
                        r_state <= ST_FIND_LO;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ sim/tb_column_occlusion_span_clipper_top.sv @@
// Self-checking testbench for column_occlusion_span_clipper_top: streams clear and clip
// requests, predicts the visible runs from its own column bitmap and checks every result.
// Depends on cosc_pkg and the RTL under src.
`default_nettype none
module tb_column_occlusion_span_clipper_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_COLS = cosc_pkg::COLS_DEF;

    typedef struct {
        logic       opcode;
        logic [6:0] span_first;
        logic [7:0] span_end;
        logic       marks_solid;
    } t_clip_req;

    typedef struct {
        logic [6:0] run_start;
        logic [6:0] run_stop;
        logic       visible;
        logic       last;
    } t_vis_run;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    t_clip_req   pending_reqs[$];
    t_vis_run    expected_runs[$];
    bit [127:0]  solid_cols = '0;
    logic        req_taken = 1'b0;
    int unsigned cyc = 0;
    int unsigned fails = 0;
    t_clip_req   next_req;

    column_occlusion_span_clipper_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // span_first[6:0], span_end[14:7], marks_solid[15]
        .s_tuser  (s_tuser),   // opcode
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // run_start[6:0], run_stop[13:7], zero pad[15:14]
        .m_tuser  (m_tuser),   // visible
        .m_tlast  (m_tlast)    // last
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit take_break();
        if (cyc >= 600 && cyc < 1400) return 1'b0;
        return $urandom_range(0, 99) < 19;
    endfunction

    task automatic add_req(input logic op, input int first, input int last_x, input logic mark);
        t_clip_req r;
        r.opcode      = op;
        r.span_first  = first[6:0];
        r.span_end    = last_x[7:0];
        r.marks_solid = mark;
        pending_reqs.push_back(r);
    endtask

    task automatic predict_runs(input t_clip_req r);
        int lim;
        int col;
        int lo;
        int cnt;
        t_vis_run v;
        if (r.opcode == cosc_pkg::OP_CLEAR) begin
            solid_cols = '0;
            return;
        end
        lim = (int'(r.span_end) > NUM_COLS) ? NUM_COLS : int'(r.span_end);
        col = int'(r.span_first);
        cnt = 0;
        while (col < lim) begin
            if (solid_cols[col]) begin
                col++;
            end else begin
                lo = col;
                while (col < lim && !solid_cols[col]) col++;
                v.run_start = lo[6:0];
                v.run_stop  = 7'(col - 1);
                v.visible   = 1'b1;
                v.last      = 1'b0;
                expected_runs.push_back(v);
                cnt++;
                if (r.marks_solid) begin
                    for (int k = lo; k < col; k++) solid_cols[k] = 1'b1;
                end
            end
        end
        if (cnt == 0) begin
            v.run_start = '0;
            v.run_stop  = '0;
            v.visible   = 1'b0;
            v.last      = 1'b1;
            expected_runs.push_back(v);
        end else begin
            v = expected_runs.pop_back();
            v.last = 1'b1;
            expected_runs.push_back(v);
        end
    endtask

    task automatic note_fail(input string msg);
        fails++;
        if (fails <= 10) $display("%t mismatch: %s", $realtime, msg);
    endtask

    // request driver and sink back-pressure
    always @(negedge i_clk) begin
        cyc <= cyc + 1;
        if (i_rst_n) begin
            if (!s_tvalid || req_taken) begin
                if (pending_reqs.size() > 0 && !take_break()) begin
                    next_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_req.marks_solid, next_req.span_end, next_req.span_first};
                    s_tuser  <= next_req.opcode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !take_break();
        end
    end

    // accepted requests feed the predictor; results are checked in order
    always @(posedge i_clk) begin
        t_clip_req r;
        t_vis_run  e;
        req_taken <= i_rst_n && s_tvalid && s_tready;
        if (i_rst_n && s_tvalid && s_tready) begin
            r.opcode      = s_tuser;
            r.span_first  = s_tdata[6:0];
            r.span_end    = s_tdata[14:7];
            r.marks_solid = s_tdata[15];
            predict_runs(r);
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_runs.size() == 0) begin
                note_fail($sformatf("unexpected result tdata=%h tuser=%b tlast=%b",
                                    m_tdata, m_tuser, m_tlast));
            end else begin
                e = expected_runs.pop_front();
                if (m_tdata !== {2'b00, e.run_stop, e.run_start} || m_tuser !== e.visible
                        || m_tlast !== e.last) begin
                    note_fail($sformatf(
                        "exp start=%0d stop=%0d vis=%b last=%b, got tdata=%h vis=%b last=%b",
                        e.run_start, e.run_stop, e.visible, e.last, m_tdata, m_tuser,
                        m_tlast));
                end
            end
        end
    end

    initial begin
        int n;
        int sel;
        int f;
        // directed: extremes, saturation, empty and hidden spans, clear
        add_req(cosc_pkg::OP_CLIP, 0, 128, 1'b0);
        add_req(cosc_pkg::OP_CLIP, 0, 255, 1'b0);
        add_req(cosc_pkg::OP_CLIP, 5, 5, 1'b0);
        add_req(cosc_pkg::OP_CLIP, 50, 10, 1'b1);
        add_req(cosc_pkg::OP_CLIP, 127, 128, 1'b1);
        add_req(cosc_pkg::OP_CLIP, 120, 255, 1'b1);
        add_req(cosc_pkg::OP_CLIP, 119, 120, 1'b1);
        add_req(cosc_pkg::OP_CLIP, 0, 1, 1'b1);
        add_req(cosc_pkg::OP_CLIP, 10, 20, 1'b1);
        add_req(cosc_pkg::OP_CLIP, 30, 31, 1'b1);
        add_req(cosc_pkg::OP_CLIP, 0, 128, 1'b0);
        add_req(cosc_pkg::OP_CLIP, 10, 20, 1'b0);
        add_req(cosc_pkg::OP_CLIP, 5, 25, 1'b1);
        add_req(cosc_pkg::OP_CLIP, 0, 128, 1'b1);
        add_req(cosc_pkg::OP_CLIP, 0, 128, 1'b0);
        add_req(cosc_pkg::OP_CLEAR, 0, 0, 1'b0);
        add_req(cosc_pkg::OP_CLIP, 0, 128, 1'b0);
        add_req(cosc_pkg::OP_CLEAR, 127, 255, 1'b1);
        add_req(cosc_pkg::OP_CLIP, 64, 127, 1'b1);
        add_req(cosc_pkg::OP_CLIP, 60, 70, 1'b0);

        // random: mostly fragment-then-sweep sequences, some plain clips and noise
        n = 0;
        while (n < 130) begin
            sel = $urandom_range(0, 99);
            if (sel < 5) begin
                add_req(cosc_pkg::OP_CLEAR, $urandom_range(0, 127), $urandom_range(0, 255),
                        1'($urandom));
                n++;
            end else if (sel < 35) begin
                add_req(cosc_pkg::OP_CLEAR, 0, 0, 1'b0);
                sel = $urandom_range(6, 30);
                for (int k = 0; k < sel; k++) begin
                    f = $urandom_range(0, NUM_COLS - 1);
                    add_req(cosc_pkg::OP_CLIP, f, f + $urandom_range(1, 3), 1'b1);
                end
                add_req(cosc_pkg::OP_CLIP, $urandom_range(0, 8), $urandom_range(112, 255),
                        1'($urandom));
                n += sel + 2;
            end else if (sel < 50) begin
                add_req(cosc_pkg::OP_CLIP, $urandom_range(0, 127), $urandom_range(0, 255),
                        1'($urandom));
                n++;
            end else begin
                f = $urandom_range(0, 127);
                add_req(cosc_pkg::OP_CLIP, f, f + $urandom_range(0, 40), 1'($urandom));
                n++;
            end
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_reqs.size() > 0 || s_tvalid || expected_runs.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fails == 0) begin
            $display("tb_column_occlusion_span_clipper_top: PASS");
        end else begin
            $display("tb_column_occlusion_span_clipper_top: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_column_occlusion_span_clipper_top: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
